>>> design/modulation_input_combiner_defines.svh
// Assertion macros for the modulation input combiner checker.
// Included by the checker file; depends on nothing else.
`ifndef MODULATION_INPUT_COMBINER_DEFINES_SVH
`define MODULATION_INPUT_COMBINER_DEFINES_SVH

// Holds in the cycle after the antecedent.
`define MIC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Holds in the same cycle as the antecedent.
`define MIC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> design/mic_pkg.sv
// Shared widths, operation codes, types and clamp functions of the combiner.
// Used by mic_combine and modulation_input_combiner; depends on nothing.
package mic_pkg;

   localparam int SRC_W  = 17;
   localparam int GAIN_W = 15;
   localparam int ACC_W  = 14;
   localparam int OP_W   = 15;
   localparam int MUL_W  = 18;
   localparam int PROD_W = 33;
   localparam int WIDE_W = 18;

   localparam logic [1:0] CMD_SET = 2'd0;
   localparam logic [1:0] CMD_ADD = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_SUB = 2'd3;

   localparam logic [ACC_W-1:0] ACC_MAX = 14'h3fff;
   localparam logic [ACC_W-1:0] MID     = 14'h2000;

   localparam logic signed [WIDE_W-1:0] WIDE_UMAX = 18'sd16383;
   localparam logic signed [WIDE_W-1:0] WIDE_SMAX = 18'sd8191;
   localparam logic signed [WIDE_W-1:0] WIDE_SMIN = -18'sd8192;
   localparam logic signed [OP_W-1:0]   OP_SMAX   = 15'sd8191;
   localparam logic signed [OP_W-1:0]   OP_SMIN   = -15'sd8192;

   typedef struct packed {
      logic [1:0] cmd;
      logic       src_signed;
      logic       mode;
   } mic_ctrl_type;

   typedef struct packed {
      logic [ACC_W-1:0] value;
      logic             mode;
   } mic_result_type;

   function automatic logic [ACC_W-1:0] clamp_unsigned(input logic signed [WIDE_W-1:0] x);
      logic [ACC_W-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > WIDE_UMAX) begin
         r = ACC_MAX;
      end else begin
         r = x[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [OP_W-1:0] clamp_signed(input logic signed [WIDE_W-1:0] x);
      logic signed [OP_W-1:0] r;
      if (x < WIDE_SMIN) begin
         r = OP_SMIN;
      end else if (x > WIDE_SMAX) begin
         r = OP_SMAX;
      end else begin
         r = x[OP_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] clamp_centered(input logic signed [WIDE_W-1:0] x);
      logic signed [OP_W-1:0] s;
      s = clamp_signed(x);
      return s[ACC_W-1:0] + MID;
   endfunction

endpackage

>>> design/mic_combine.sv
// Combine stage: folds the scaled entry value into the accumulator.
// Depends on mic_pkg.
module mic_combine (
   input  mic_pkg::mic_ctrl_type          ctrl,
   input  logic signed [mic_pkg::OP_W-1:0]   base,
   input  logic signed [mic_pkg::OP_W-1:0]   op,
   input  logic signed [mic_pkg::PROD_W-1:0] prod,
   output mic_pkg::mic_result_type        result
);
   import mic_pkg::*;

   logic signed [WIDE_W-1:0] base_wide;
   logic signed [WIDE_W-1:0] op_wide;
   logic signed [WIDE_W-1:0] sum;
   logic signed [WIDE_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_shifted;
   logic signed [WIDE_W-1:0] shifted;

   assign base_wide    = {{(WIDE_W-OP_W){base[OP_W-1]}}, base};
   assign op_wide      = {{(WIDE_W-OP_W){op[OP_W-1]}}, op};
   assign sum          = base_wide + op_wide;
   assign diff         = base_wide - op_wide;
   assign prod_shifted = ctrl.src_signed ? (prod >>> 13) : (prod >>> 14);
   assign shifted      = prod_shifted[WIDE_W-1:0];

   always_comb begin
      result = '0;
      case (ctrl.cmd)
         CMD_SET: begin
            result.mode  = ctrl.src_signed;
            result.value = ctrl.src_signed ? (op[ACC_W-1:0] + MID) : op[ACC_W-1:0];
         end
         CMD_ADD: begin
            result.mode  = ctrl.mode;
            result.value = ctrl.mode ? clamp_centered(sum) : clamp_unsigned(sum);
         end
         CMD_SUB: begin
            result.mode  = ctrl.mode;
            result.value = ctrl.mode ? clamp_centered(diff) : clamp_unsigned(diff);
         end
         CMD_MUL: begin
            result.mode = ctrl.mode | ctrl.src_signed;
            if (!ctrl.mode && ctrl.src_signed) begin
               // A negative product wraps to a huge unsigned value and saturates.
               result.value = (prod < 0) ? ACC_MAX : clamp_centered(shifted);
            end else if (ctrl.mode) begin
               result.value = clamp_centered(shifted);
            end else begin
               result.value = clamp_unsigned(shifted);
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

>>> design/modulation_input_combiner.sv
// Modulation input combiner top level: sequencer, shared multiplier, state.
// Depends on mic_pkg and mic_combine.
//
// Each request on the req_ channel is one entry of a controller list. The
// block scales the source by the entry gain, clamps it, and combines it into
// a 14-bit accumulator with set, add, multiply or subtract. Every request
// yields exactly one response on the rsp_ channel, carrying the updated
// value, the signed-offset mode and a copy of tlast. After the response of
// an entry with tlast set, the accumulator and the mode return to zero.
// One signed 18 by 18 multiplier is shared by the gain scaling and the
// combine multiply, so a request passes through four sequencer steps:
// scale, clamp, multiply and done. The response becomes valid in the same
// cycle as req_tready rises, so a new request is taken only once the
// previous one has been answered.
// A stalled response holds its register; the sequencer waits in its last
// step until the response register is free, and req_tready stays low.
// Synchronous reset clears the accumulator, the mode, the sequencer and the response valid flag.
module modulation_input_combiner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // source_value[16:0], scale[32:18], zero fill
   input  logic [2:0]  req_tuser,  // source_signed[0], cmd[2:1]
   input  logic        req_tlast,  // last_entry
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // value[13:0], zero fill
   output logic [0:0]  rsp_tuser,  // is_signed[0]
   output logic        rsp_tlast   // final_res
);
   import mic_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCALE = 3'd1;
   localparam logic [2:0] S_CLAMP = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic signed [SRC_W-1:0]  src_ff, src_in;
   logic                     src_signed_ff, src_signed_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic                     last_ff, last_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [OP_W-1:0]   op_ff, op_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     mode_ff, mode_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]         rsp_value_ff, rsp_value_in;
   logic                     rsp_mode_ff, rsp_mode_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     req_fire;
   logic                     done_fire;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic signed [OP_W-1:0]   acc_wide;
   logic signed [OP_W-1:0]   base;
   logic signed [WIDE_W-1:0] scaled;
   mic_ctrl_type             ctrl;
   mic_result_type           result;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign done_fire  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign acc_wide = $signed({1'b0, acc_ff});
   assign base     = mode_ff ? (acc_wide - $signed({1'b0, MID})) : acc_wide;
   assign scaled   = prod_ff[PROD_W-1:15];

   always_comb begin
      if (state_ff == S_SCALE) begin
         mul_a = {src_ff[SRC_W-1], src_ff};
         mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_ff});
      end else begin
         mul_a = {{(MUL_W-OP_W){base[OP_W-1]}}, base};
         mul_b = {{(MUL_W-OP_W){op_ff[OP_W-1]}}, op_ff};
      end
   end

   assign mul_p = mul_a * mul_b;

   assign ctrl.cmd        = cmd_ff;
   assign ctrl.src_signed = src_signed_ff;
   assign ctrl.mode       = mode_ff;

   mic_combine u_combine (
      .ctrl   (ctrl),
      .base   (base),
      .op     (op_ff),
      .prod   (prod_ff),
      .result (result)
   );

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      src_signed_in = src_signed_ff;
      gain_in       = gain_ff;
      cmd_in        = cmd_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;
      op_in         = op_ff;
      acc_in        = acc_ff;
      mode_in       = mode_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               src_in        = req_tdata[SRC_W-1:0];
               gain_in       = req_tdata[SRC_W+GAIN_W:SRC_W+1];
               src_signed_in = req_tuser[0];
               cmd_in        = req_tuser[2:1];
               last_in       = req_tlast;
               state_in      = S_SCALE;
            end
         end
         S_SCALE: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            op_in    = src_signed_ff ? clamp_signed(scaled) : $signed({1'b0, clamp_unsigned(scaled)});
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_fire) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result.value;
               rsp_mode_in  = result.mode;
               rsp_last_in  = last_ff;
               acc_in       = last_ff ? '0 : result.value;
               mode_in      = last_ff ? 1'b0 : result.mode;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      src_signed_ff <= src_signed_in;
      gain_ff       <= gain_in;
      cmd_ff        <= cmd_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      op_ff         <= op_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_value_ff};
   assign rsp_tuser  = rsp_mode_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> design/mic_checker.sv
// Port-level checker for the modulation input combiner, bound to the top level.
// Depends on modulation_input_combiner_defines.svh.
`include "modulation_input_combiner_defines.svh"

module mic_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `MIC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")
   `MIC_ASSERT_NEXT(a_busy_after_request, clock, reset, req_tvalid && req_tready, !req_tready, "ready stayed high after a request")
   `MIC_ASSERT_NEXT(a_no_early_response, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "response appeared one cycle after a request")
   `MIC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled response changed")

endmodule

bind modulation_input_combiner mic_checker u_mic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
